// File: src/ptob_pkg.sv
// ----------------------------------------------------------------------------
// ptob_pkg
// shared types, codes and compare helpers for the order book core
// ----------------------------------------------------------------------------
package ptob_pkg;

  localparam int MAX_ORDERS_DEF = 256;
  localparam int ARRIVAL_W      = 48;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_REDUCE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic                 valid;
    logic                 side;
    logic [31:0]          oid;
    logic [31:0]          price;
    logic [31:0]          quantity;
    logic [31:0]          maker;
    logic [ARRIVAL_W-1:0] arrival;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // strictly better price for the given side
  function automatic logic price_better(input logic s, input logic [31:0] a,
                                        input logic [31:0] b);
    price_better = (s == SIDE_BID) ? (a > b) : (a < b);
  endfunction

  // price first, then oldest arrival
  function automatic logic slot_better(input logic s,
                                       input logic [31:0] ap,
                                       input logic [ARRIVAL_W-1:0] aa,
                                       input logic [31:0] bp,
                                       input logic [ARRIVAL_W-1:0] ba);
    if (ap != bp) begin
      slot_better = price_better(s, ap, bp);
    end else begin
      slot_better = (aa < ba);
    end
  endfunction

endpackage

// File: src/ptob_ram.sv
// ----------------------------------------------------------------------------
// ptob_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module ptob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/price_time_order_book_core.sv
// ----------------------------------------------------------------------------
// price_time_order_book_core
// limit order book with price-time priority over a fixed table of slots
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid/in_ready, op, oid, side,         | in
//          | price, quantity, party                    |
//  result  | out_valid/out_ready, accepted, fill_*,    | out
//          | bid_present, best_*_price, ask_present    |
//
// a request passes through these steps: accept, one read of the slot memory
// per slot (single read port), the last read data, a drain step, the update;
// the result is ready after the update, and the next request is taken only
// once the update is done
// after reset a clearing pass writes every slot, in_ready low
// a result waits in the output register; the update cycle holds until it is free
// in_ready is high only between requests
// ----------------------------------------------------------------------------
module price_time_order_book_core #(
  parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] oid,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [31:0] party,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        fill_valid,
  output logic [31:0] fill_maker,
  output logic [31:0] fill_price,
  output logic [31:0] fill_quantity,
  output logic        bid_present,
  output logic [31:0] best_bid_price,
  output logic        ask_present,
  output logic [31:0] best_ask_price
);

  localparam int IW = $clog2(MAX_ORDERS);
  localparam int CW = IW + 1;
  localparam int AW = ptob_pkg::ARRIVAL_W;

  // sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] iss;          // next slot to read, or clear pointer
  logic          rvalid_d;     // read data in rdata belongs to the scan
  logic [IW-1:0] ridx;         // slot index of rdata
  logic [AW-1:0] arrival_counter;

  // latched request
  logic [1:0]  l_op;
  logic [31:0] l_id;
  logic        l_side;
  logic [31:0] l_price;
  logic [31:0] l_qty;
  logic [31:0] l_maker;

  // scan results
  logic              match;
  logic [IW-1:0]     midx;
  logic              free_found;
  logic [IW-1:0]     fidx;
  logic              has  [2];
  ptob_pkg::slot_t   best [2];
  logic [IW-1:0]     bidx [2];
  logic              has2 [2];
  logic [31:0]       p2   [2];

  // memory port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  ptob_pkg::slot_t   ram_wdata;
  ptob_pkg::slot_t   e;

  // update cycle
  logic              go;
  logic              upd_we;
  logic [IW-1:0]     upd_addr;
  ptob_pkg::slot_t   upd_data;
  logic              ctr_inc;
  logic              r_acc, r_fv;
  logic [31:0]       r_fm, r_fp, r_fq;
  logic              r_bh, r_ah;
  logic [31:0]       r_bp, r_ap;
  logic [31:0]       bq, take, rem;

  ptob_ram #(
    .WIDTH (ptob_pkg::SLOT_W),
    .DEPTH (MAX_ORDERS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss[IW-1:0]),
    .rdata (e)
  );

  assign in_ready = (state == ST_IDLE);
  assign go       = (state == ST_APPLY) && (!out_valid || out_ready);

  // clearing pass writes empty slots, otherwise the update cycle writes
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = (iss != CW'(MAX_ORDERS));
      ram_waddr = iss[IW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = go && upd_we;
      ram_waddr = upd_addr;
      ram_wdata = upd_data;
    end
  end

  // outcome of the request from the scan results
  always_comb begin
    bq       = best[l_side].quantity;
    take     = (l_qty < bq) ? l_qty : bq;
    rem      = bq - take;
    r_acc    = 1'b0;
    r_fv     = 1'b0;
    r_fm     = '0;
    r_fp     = '0;
    r_fq     = '0;
    r_bh     = has[0];
    r_bp     = best[0].price;
    r_ah     = has[1];
    r_ap     = best[1].price;
    upd_we   = 1'b0;
    upd_addr = fidx;
    upd_data = '0;
    ctr_inc  = 1'b0;
    case (l_op)
      ptob_pkg::OP_ADD: begin
        if (!match && free_found) begin
          r_acc    = 1'b1;
          upd_we   = 1'b1;
          upd_addr = fidx;
          upd_data = '{valid: 1'b1, side: l_side, oid: l_id, price: l_price,
                       quantity: l_qty, maker: l_maker, arrival: arrival_counter};
          ctr_inc  = 1'b1;
          if (l_side == ptob_pkg::SIDE_BID) begin
            if (!r_bh || (l_price > r_bp)) begin
              r_bp = l_price;
            end
            r_bh = 1'b1;
          end else begin
            if (!r_ah || (l_price < r_ap)) begin
              r_ap = l_price;
            end
            r_ah = 1'b1;
          end
        end
      end
      ptob_pkg::OP_CANCEL: begin
        // the canceled order was already left out of the best search
        if (match) begin
          r_acc    = 1'b1;
          upd_we   = 1'b1;
          upd_addr = midx;
        end
      end
      ptob_pkg::OP_REDUCE: begin
        if ((l_qty != '0) && has[l_side]) begin
          r_acc             = 1'b1;
          r_fv              = 1'b1;
          r_fm              = best[l_side].maker;
          r_fp              = best[l_side].price;
          r_fq              = take;
          upd_we            = 1'b1;
          upd_addr          = bidx[l_side];
          upd_data          = best[l_side];
          upd_data.quantity = rem;
          upd_data.valid    = (rem != '0);
          // order gone: runner-up of that side takes over
          if (rem == '0) begin
            if (l_side == ptob_pkg::SIDE_BID) begin
              r_bh = has2[0];
              r_bp = p2[0];
            end else begin
              r_ah = has2[1];
              r_ap = p2[1];
            end
          end
        end
      end
      default: begin
        r_acc = 1'b1;
      end
    endcase
    if (!r_bh) begin
      r_bp = '0;
    end
    if (!r_ah) begin
      r_ap = '0;
    end
  end

  // sequencer and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      iss             <= '0;
      rvalid_d        <= 1'b0;
      arrival_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (iss == CW'(MAX_ORDERS)) begin
            state <= ST_IDLE;
          end else begin
            iss <= iss + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_SCAN;
            iss      <= '0;
            rvalid_d <= 1'b0;
          end
        end
        ST_SCAN: begin
          rvalid_d <= (iss != CW'(MAX_ORDERS));
          ridx     <= iss[IW-1:0];
          if (iss != CW'(MAX_ORDERS)) begin
            iss <= iss + 1'b1;
          end else if (!rvalid_d) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (go) begin
            state <= ST_IDLE;
            if (ctr_inc) begin
              arrival_counter <= arrival_counter + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request latch, scan bookkeeping and result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      l_op       <= op;
      l_id       <= oid;
      l_side     <= side;
      l_price    <= price;
      l_qty      <= quantity;
      l_maker    <= party;
      match      <= 1'b0;
      free_found <= 1'b0;
      has[0]     <= 1'b0;
      has[1]     <= 1'b0;
      has2[0]    <= 1'b0;
      has2[1]    <= 1'b0;
    end else if (state == ST_SCAN && rvalid_d) begin
      if (e.valid) begin
        if (e.oid == l_id) begin
          match <= 1'b1;
          midx  <= ridx;
        end
        // a canceled order takes no part in the best search
        if (!(l_op == ptob_pkg::OP_CANCEL && e.oid == l_id)) begin
          if (!has[e.side] || ptob_pkg::slot_better(e.side, e.price, e.arrival,
                                best[e.side].price, best[e.side].arrival)) begin
            if (has[e.side]) begin
              has2[e.side] <= 1'b1;
              p2[e.side]   <= best[e.side].price;
            end
            has[e.side]  <= 1'b1;
            best[e.side] <= e;
            bidx[e.side] <= ridx;
          end else if (!has2[e.side] ||
                       ptob_pkg::price_better(e.side, e.price, p2[e.side])) begin
            has2[e.side] <= 1'b1;
            p2[e.side]   <= e.price;
          end
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        fidx       <= ridx;
      end
    end
    if (go) begin
      accepted       <= r_acc;
      fill_valid     <= r_fv;
      fill_maker     <= r_fm;
      fill_price     <= r_fp;
      fill_quantity  <= r_fq;
      bid_present    <= r_bh;
      best_bid_price <= r_bp;
      ask_present    <= r_ah;
      best_ask_price <= r_ap;
    end
  end

endmodule
